// ===== design/tcbs_pkg.sv =====
// tcbs_pkg: shared types, constants and the helper function of the text console buffer
// holds grid geometry, event codes, the controller state type and command/status structs
// no dependencies
package tcbs_pkg;

  localparam int ROWS    = 25;
  localparam int COLUMNS = 80;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 3;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int SRC_W  = CNT_W + 1;

  localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'd10;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [KIND_W-1:0] EV_STORED    = 3'd0;
  localparam logic [KIND_W-1:0] EV_DROPPED   = 3'd1;
  localparam logic [KIND_W-1:0] EV_NEXT_LINE = 3'd2;
  localparam logic [KIND_W-1:0] EV_SCROLLED  = 3'd3;
  localparam logic [KIND_W-1:0] EV_READ      = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic clear_step;
    logic scroll_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scroll_last;
    logic need_scroll;
  } dp_status_t;

  // linear cell address, row-major
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    int lin;
    lin = int'(row) * COLUMNS + int'(col);
    return lin[ADDR_W-1:0];
  endfunction

endpackage

// ===== design/tcbs_ram.sv =====
// tcbs_ram: generic single write port, single read port ram with registered read
// depends on nothing
module tcbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tcbs_ctrl.sv =====
// tcbs_ctrl: controller state machine of the text console buffer
// depends on tcbs_pkg; drives datapath commands, input stall and output valid
module tcbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_stall,
  input  tcbs_pkg::dp_status_t status,
  output tcbs_pkg::ctrl_cmd_t  cmd,
  output logic                in_stall,
  output logic                out_valid
);
  import tcbs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = status.need_scroll ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        if (status.scroll_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_nxt = in_valid ? ST_EXEC : ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
      end
      ST_DONE: begin
        // result moves out and the next transaction can enter together
        in_stall     = !slot_free;
        cmd.load_out = slot_free;
        cmd.accept   = slot_free && in_valid;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");

  a_scroll_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL && status.scroll_last) |=> (state_r == ST_DONE))
    else $error("scroll did not finish into done");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

// ===== design/tcbs_dp.sv =====
// tcbs_dp: datapath of the text console buffer: cursor, item and result registers,
// clearing and scroll sweeps over the character ram
// depends on tcbs_pkg and tcbs_ram
module tcbs_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcbs_pkg::ctrl_cmd_t        cmd,
  output tcbs_pkg::dp_status_t       status,
  input  logic                       in_req_type,
  input  logic [tcbs_pkg::CHAR_W-1:0] in_character,
  input  logic [tcbs_pkg::ROW_W-1:0]  in_read_row,
  input  logic [tcbs_pkg::COL_W-1:0]  in_read_column,
  output logic [tcbs_pkg::KIND_W-1:0] out_event_kind,
  output logic [tcbs_pkg::ROW_W-1:0]  out_cell_row,
  output logic [tcbs_pkg::COL_W-1:0]  out_cell_column,
  output logic [tcbs_pkg::CHAR_W-1:0] out_cell_char,
  output logic [tcbs_pkg::ROW_W-1:0]  out_cursor_row_now,
  output logic [tcbs_pkg::COL_W-1:0]  out_cursor_column_now
);
  import tcbs_pkg::*;

  logic [ROW_W-1:0]  cur_line_r, cur_line_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  wr_idx;
  logic [SRC_W-1:0]  src;
  logic              src_ok_r;

  logic              req_r;
  logic [CHAR_W-1:0] char_r;
  logic [ROW_W-1:0]  rrow_r;
  logic [COL_W-1:0]  rcol_r;

  logic [KIND_W-1:0] res_kind_r, res_kind_nxt;
  logic [ROW_W-1:0]  res_row_r, res_row_nxt;
  logic [COL_W-1:0]  res_col_r, res_col_nxt;
  logic [CHAR_W-1:0] res_char_r, res_char_nxt;

  logic [KIND_W-1:0] o_kind_r;
  logic [ROW_W-1:0]  o_row_r;
  logic [COL_W-1:0]  o_col_r;
  logic [CHAR_W-1:0] o_char_r;
  logic [ROW_W-1:0]  o_cur_row_r;
  logic [COL_W-1:0]  o_cur_col_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic in_grid;
  logic line_last;
  logic put_ok;

  tcbs_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // scroll reads one row ahead of the cell it rewrites
  assign src    = SRC_W'(cnt_r) + SRC_W'(COLUMNS);
  assign wr_idx = cnt_r - CNT_W'(1);

  assign in_grid   = (int'(rrow_r) < ROWS) && (int'(rcol_r) < COLUMNS);
  assign line_last = (int'(cur_line_r) + 1) >= ROWS;
  assign put_ok    = (char_r != '0) && ((int'(cur_col_r) + 1) < COLUMNS)
                     && (int'(cur_line_r) < ROWS);

  assign status.clear_last  = (cnt_r == CNT_W'(CELLS - 1));
  assign status.scroll_last = (cnt_r == CNT_W'(CELLS));
  assign status.need_scroll = (req_r == REQ_PUT) && (char_r == NEWLINE_BYTE) && line_last;

  always_comb begin
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    cnt_nxt      = cnt_r;
    res_kind_nxt = res_kind_r;
    res_row_nxt  = res_row_r;
    res_col_nxt  = res_col_r;
    res_char_nxt = res_char_r;
    ram_we       = 1'b0;
    ram_waddr    = cell_addr(cur_line_r, cur_col_r);
    ram_wdata    = char_r;
    ram_raddr    = cell_addr(in_read_row, in_read_column);

    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r[ADDR_W-1:0];
      ram_wdata = '0;
      cnt_nxt   = cnt_r + CNT_W'(1);
    end

    if (cmd.exec) begin
      res_row_nxt  = '0;
      res_col_nxt  = '0;
      res_char_nxt = '0;
      if (req_r == REQ_READ) begin
        res_kind_nxt = EV_READ;
        res_row_nxt  = rrow_r;
        res_col_nxt  = rcol_r;
        res_char_nxt = in_grid ? ram_rdata : '0;
      end else if (char_r == NEWLINE_BYTE) begin
        cur_col_nxt = '0;
        if (line_last) begin
          cur_line_nxt = ROW_W'(ROWS - 1);
          res_kind_nxt = EV_SCROLLED;
          cnt_nxt      = '0;
        end else begin
          cur_line_nxt = cur_line_r + ROW_W'(1);
          res_kind_nxt = EV_NEXT_LINE;
        end
      end else if (put_ok) begin
        ram_we       = 1'b1;
        cur_col_nxt  = cur_col_r + COL_W'(1);
        res_kind_nxt = EV_STORED;
        res_row_nxt  = cur_line_r;
        res_col_nxt  = cur_col_r;
        res_char_nxt = char_r;
      end else begin
        res_kind_nxt = EV_DROPPED;
      end
    end

    if (cmd.scroll_step) begin
      ram_raddr = src[ADDR_W-1:0];
      cnt_nxt   = cnt_r + CNT_W'(1);
      if (cnt_r != '0) begin
        ram_we    = 1'b1;
        ram_waddr = wr_idx[ADDR_W-1:0];
        // bottom row has no source row and is cleared
        ram_wdata = src_ok_r ? ram_rdata : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_line_r <= '0;
      cur_col_r  <= '0;
      cnt_r      <= '0;
    end else begin
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_ok_r   <= (src < SRC_W'(CELLS));
    res_kind_r <= res_kind_nxt;
    res_row_r  <= res_row_nxt;
    res_col_r  <= res_col_nxt;
    res_char_r <= res_char_nxt;
    if (cmd.accept) begin
      req_r  <= in_req_type;
      char_r <= in_character;
      rrow_r <= in_read_row;
      rcol_r <= in_read_column;
    end
    if (cmd.load_out) begin
      o_kind_r    <= res_kind_r;
      o_row_r     <= res_row_r;
      o_col_r     <= res_col_r;
      o_char_r    <= res_char_r;
      o_cur_row_r <= cur_line_r;
      o_cur_col_r <= cur_col_r;
    end
  end

  assign out_event_kind        = o_kind_r;
  assign out_cell_row          = o_row_r;
  assign out_cell_column       = o_col_r;
  assign out_cell_char         = o_char_r;
  assign out_cursor_row_now    = o_cur_row_r;
  assign out_cursor_column_now = o_cur_col_r;

`ifndef SYNTHESIS
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_line_r) < ROWS) && (int'(cur_col_r) < COLUMNS))
    else $error("cursor left the grid");

  a_scroll_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && status.need_scroll) |=> (cur_col_r == '0 && cnt_r == '0))
    else $error("scroll sweep not set up");

  a_scroll_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scroll_step |-> (cnt_r <= CNT_W'(CELLS)))
    else $error("scroll sweep ran past the grid");
`endif

endmodule

// ===== design/text_console_buffer_scroll.sv =====
// text_console_buffer_scroll: 25 x 80 character store with cursor and scroll on newline
// an accepted transaction passes through EXEC (and SCROLL) and DONE before its result is presented
// the next transaction can enter in DONE as the result moves out, unless out_stall holds DONE;
// a newline on the bottom row adds a scroll sweep over the single-port-pair character ram
// reset: synchronous, active low; a clearing pass over all ROWS*COLUMNS cells zeroes
// the ram while in_stall stays high, cursor returns to row 0 column 0
module text_console_buffer_scroll (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [tcbs_pkg::CHAR_W-1:0] in_character,
  input  logic [tcbs_pkg::ROW_W-1:0]  in_read_row,
  input  logic [tcbs_pkg::COL_W-1:0]  in_read_column,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcbs_pkg::KIND_W-1:0] out_event_kind,
  output logic [tcbs_pkg::ROW_W-1:0]  out_cell_row,
  output logic [tcbs_pkg::COL_W-1:0]  out_cell_column,
  output logic [tcbs_pkg::CHAR_W-1:0] out_cell_char,
  output logic [tcbs_pkg::ROW_W-1:0]  out_cursor_row_now,
  output logic [tcbs_pkg::COL_W-1:0]  out_cursor_column_now
);
  import tcbs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tcbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall),
    .out_valid(out_valid)
  );

  tcbs_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_req_type          (in_req_type),
    .in_character         (in_character),
    .in_read_row          (in_read_row),
    .in_read_column       (in_read_column),
    .out_event_kind       (out_event_kind),
    .out_cell_row         (out_cell_row),
    .out_cell_column      (out_cell_column),
    .out_cell_char        (out_cell_char),
    .out_cursor_row_now   (out_cursor_row_now),
    .out_cursor_column_now(out_cursor_column_now)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// testbench for text_console_buffer_scroll: puts, newlines, scrolls and cell reads,
// every result checked against a cycle-free model of the grid and cursor
// depends on design/tcbs_pkg.sv and design/text_console_buffer_scroll.sv
module testbench;
  import tcbs_pkg::*;

  localparam int TOTAL_ITEMS = 1450;
  localparam int QUIET_LIMIT = 10000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic              req_type;
    logic [CHAR_W-1:0] character;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_column;
  } console_req_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
  } console_event_t;

  class console_scoreboard;
    bit [CHAR_W-1:0] grid [ROWS][COLUMNS];
    bit [ROW_W-1:0]  cur_row;
    bit [COL_W-1:0]  cur_col;
    console_event_t  expected_events [$];
    int              failures;

    // advance the grid and cursor by one transaction and queue its event
    function void note_request(console_req_t rq);
      console_event_t ev;
      ev = '{default: '0};
      if (rq.req_type == REQ_READ) begin
        ev.kind = EV_READ;
        ev.row  = rq.read_row;
        ev.col  = rq.read_column;
        if (rq.read_row < ROWS && rq.read_column < COLUMNS)
          ev.ch = grid[rq.read_row][rq.read_column];
      end else if (rq.character == NEWLINE_BYTE) begin
        cur_col = '0;
        if (cur_row + 1 < ROWS) begin
          cur_row++;
          ev.kind = EV_NEXT_LINE;
        end else begin
          for (int r = 0; r < ROWS - 1; r++)
            grid[r] = grid[r + 1];
          for (int c = 0; c < COLUMNS; c++)
            grid[ROWS - 1][c] = '0;
          ev.kind = EV_SCROLLED;
        end
      end else if (rq.character == '0 || cur_col + 1 >= COLUMNS) begin
        ev.kind = EV_DROPPED;
      end else begin
        ev.kind = EV_STORED;
        ev.row  = cur_row;
        ev.col  = cur_col;
        ev.ch   = rq.character;
        grid[cur_row][cur_col] = rq.character;
        cur_col++;
      end
      ev.cur_row = cur_row;
      ev.cur_col = cur_col;
      expected_events.push_back(ev);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_event(console_event_t got);
      console_event_t want;
      if (expected_events.size() == 0) begin
        $error("event_kind: expected no transaction, actual %0d", got.kind);
        failures++;
        return;
      end
      want = expected_events.pop_front();
      compare_field("event_kind", 8'(want.kind), 8'(got.kind));
      compare_field("cell_row", 8'(want.row), 8'(got.row));
      compare_field("cell_column", 8'(want.col), 8'(got.col));
      compare_field("cell_char", want.ch, got.ch);
      compare_field("cursor_row_now", 8'(want.cur_row), 8'(got.cur_row));
      compare_field("cursor_column_now", 8'(want.cur_col), 8'(got.cur_col));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_req_type = REQ_PUT;
  logic [CHAR_W-1:0] in_character = '0;
  logic [ROW_W-1:0]  in_read_row = '0;
  logic [COL_W-1:0]  in_read_column = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KIND_W-1:0] out_event_kind;
  logic [ROW_W-1:0]  out_cell_row;
  logic [COL_W-1:0]  out_cell_column;
  logic [CHAR_W-1:0] out_cell_char;
  logic [ROW_W-1:0]  out_cursor_row_now;
  logic [COL_W-1:0]  out_cursor_column_now;

  console_scoreboard sb = new();
  int  sent = 0;
  int  quiet_cycles = 0;
  bit  steady = 1'b0;

  text_console_buffer_scroll DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_character          (in_character),
    .in_read_row           (in_read_row),
    .in_read_column        (in_read_column),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_event_kind        (out_event_kind),
    .out_cell_row          (out_cell_row),
    .out_cell_column       (out_cell_column),
    .out_cell_char         (out_cell_char),
    .out_cursor_row_now    (out_cursor_row_now),
    .out_cursor_column_now (out_cursor_column_now)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_event('{out_event_kind, out_cell_row, out_cell_column, out_cell_char,
                       out_cursor_row_now, out_cursor_column_now});
  end

  // the clearing pass after reset and each scroll sweep hold off transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(input logic rt, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
    console_req_t rq;
    rq = '{rt, ch, rr, rc};
    steady = (sent >= 600 && sent < 800);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= rt;
    in_character   <= ch;
    in_read_row    <= rr;
    in_read_column <= rc;
    do @(posedge clk); while (in_stall);
    sb.note_request(rq);
    sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
  endtask

  initial begin
    int  mode;
    int  pick;
    int  line_len;
    bit  first_line;
    logic [CHAR_W-1:0] ch;

    first_line = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty cell, field extremes, ignored fields, out-of-grid reads
    send_item(REQ_READ, 8'hFF, 5'd0, 7'd0);
    send_item(REQ_PUT, 8'h48, 5'd31, 7'd127);
    send_item(REQ_PUT, 8'h00, 5'd0, 7'd0);
    send_item(REQ_PUT, 8'hFF, 5'd0, 7'd0);
    send_item(REQ_PUT, 8'h01, 5'd24, 7'd79);
    send_item(REQ_PUT, 8'h80, 5'd0, 7'd0);
    send_item(REQ_READ, 8'h00, 5'd0, 7'd0);
    send_item(REQ_READ, 8'hFF, 5'd0, 7'd1);
    send_item(REQ_READ, NEWLINE_BYTE, 5'd0, 7'd3);
    send_item(REQ_READ, 8'h00, 5'd31, 7'd127);
    send_item(REQ_READ, 8'h00, 5'd25, 7'd0);
    send_item(REQ_READ, 8'h00, 5'd0, 7'd80);
    send_item(REQ_READ, 8'h00, 5'd24, 7'd79);
    send_item(REQ_PUT, NEWLINE_BYTE, 5'd31, 7'd127);
    send_item(REQ_PUT, 8'h78, 5'd0, 7'd0);
    send_item(REQ_READ, 8'h00, 5'd1, 7'd0);
    send_item(REQ_READ, 8'h00, 5'd0, 7'd4);
    send_item(REQ_PUT, NEWLINE_BYTE, 5'd0, 7'd0);
    send_item(REQ_READ, 8'h00, 5'd2, 7'd0);
    wait_drained();

    // random: lines of text ended by newline, read bursts, noise and pauses
    while (sent < TOTAL_ITEMS) begin
      mode = first_line ? 0 : $urandom_range(0, 19);
      if (mode < 12) begin
        pick = $urandom_range(0, 99);
        if (first_line || pick < 15)
          line_len = $urandom_range(70, 90);
        else if (pick < 50)
          line_len = $urandom_range(0, 40);
        else
          line_len = $urandom_range(0, 8);
        first_line = 1'b0;
        repeat (line_len) begin
          ch = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
          send_item(REQ_PUT, ch, 5'($urandom), 7'($urandom));
        end
        send_item(REQ_PUT, NEWLINE_BYTE, 5'($urandom), 7'($urandom));
      end else if (mode < 17) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 4) != 0)
            send_item(REQ_READ, 8'($urandom), 5'($urandom_range(0, sb.cur_row)),
                      7'($urandom_range(0, COLUMNS - 1)));
          else
            send_item(REQ_READ, 8'($urandom), 5'($urandom), 7'($urandom));
        end
      end else if (mode < 19) begin
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_events.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
